/* design/tilt_compensated_compass_heading_macros.svh */
// Assertion macros for the compass heading block.
// Taken in by the top level; SYNTH empties every macro.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_MACROS_SVH
`ifndef SYNTH
`define TCCH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compass heading assertion failed");
`define TCCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compass heading assertion failed");
`else
`define TCCH_ASSERT_NOW(lbl, ante, cons)
`define TCCH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/tcch_pkg.sv */
// Types, constants and per-stage functions of the compass heading pipeline.
// Used by tilt_compensated_compass_heading; depends on nothing else.
package tcch_pkg;

  typedef enum logic [1:0] {ST_OK, ST_ZERO_ACC, ST_BAD_CAL, ST_PITCH} status_t;

  typedef enum logic [2:0] {
    REG_X_LOW, REG_Y_LOW, REG_Z_LOW, REG_X_HIGH, REG_Y_HIGH, REG_Z_HIGH
  } reg_idx_t;

  localparam int REG_COUNT = 6;
  localparam logic [REG_COUNT-1:0][15:0] CFG_RESET = {
    16'(385), 16'(675), 16'(578), 16'(-1264), 16'(-891), 16'(-924)
  };

  localparam int HALF_TURN    = 180 * 16384;
  localparam int CIRCLE_CODES = 360 * 64;
  localparam int N_CORD       = 17;
  localparam int ATAN_T [N_CORD] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14
  };

  // stage map
  localparam int ST_SQ   = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_SQS  = 3;
  localparam int N_SQS   = 32;
  localparam int N_NQ    = 19;
  localparam int ST_PREP = ST_SQS + N_SQS;
  localparam int ST_DVP  = ST_PREP + 1;
  localparam int N_DIV   = 17;
  localparam int ST_CPIN = ST_DVP + N_DIV;
  localparam int ST_CPS  = ST_CPIN + 1;
  localparam int N_SQC   = 17;
  localparam int ST_RIN  = ST_CPS + N_SQC;
  localparam int ST_RDV  = ST_RIN + 1;
  localparam int ST_CRIN = ST_RDV + N_DIV;
  localparam int ST_CRS  = ST_CRIN + 1;
  localparam int ST_MUL  = ST_CRS + N_SQC;
  localparam int ST_ACC  = ST_MUL + 1;
  localparam int ST_YSUM = ST_ACC + 1;
  localparam int ST_CPRE = ST_YSUM + 1;
  localparam int ST_CORD = ST_CPRE + 1;
  localparam int ST_FIN  = ST_CORD + N_CORD;
  localparam int N_ST    = ST_FIN + 1;

  typedef struct packed {
    logic                vld;
    status_t             stat;
    logic signed [15:0]  ax;
    logic signed [15:0]  ay;
    logic signed [15:0]  az;
    logic [31:0]         sqx;
    logic [31:0]         sqy;
    logic [31:0]         sqz;
    logic [63:0]         sv;
    logic [63:0]         sr;
    logic [2:0]          nneg;
    logic [2:0]          novf;
    logic [2:0][34:0]    nrem;
    logic [2:0][16:0]    nd;
    logic [2:0][18:0]    nq;
    logic [2:0][17:0]    nv;
    logic [32:0]         dsor;
    logic [48:0]         drem0;
    logic [48:0]         drem1;
    logic [16:0]         dq0;
    logic [16:0]         dq1;
    logic signed [17:0]  sin_p;
    logic signed [17:0]  ayn;
    logic signed [17:0]  sin_r;
    logic [16:0]         cos_p;
    logic [33:0]         rrem;
    logic [16:0]         rq;
    logic                rovf;
    logic signed [35:0]  p1;
    logic signed [35:0]  p2;
    logic signed [35:0]  p3;
    logic signed [35:0]  p4;
    logic signed [35:0]  p5;
    logic signed [53:0]  t1;
    logic signed [53:0]  t2;
    logic signed [55:0]  cx;
    logic signed [55:0]  cy;
    logic signed [23:0]  ang;
    logic                nullv;
    logic [14:0]         hdg;
  } ctx_t;

  // one bit of a floor square root, 64-bit working values
  function automatic ctx_t sqrt_bit(ctx_t c, int k);
    logic [63:0] b;
    b = 64'(1) << (2 * k);
    if (c.sv >= c.sr + b) begin
      c.sv = c.sv - (c.sr + b);
      c.sr = (c.sr >> 1) + b;
    end else begin
      c.sr = c.sr >> 1;
    end
    return c;
  endfunction

  function automatic ctx_t st_entry(logic vld, logic [2:0][15:0] m,
                                    logic signed [15:0] ax, logic signed [15:0] ay,
                                    logic signed [15:0] az,
                                    logic [REG_COUNT-1:0][15:0] cfg);
    ctx_t c;
    logic signed [16:0] lo, hi, raw, dd, rl;
    logic signed [18:0] num;
    logic [18:0] nm;
    c = '0;
    c.vld = vld;
    c.ax = ax;
    c.ay = ay;
    c.az = az;
    if (ax == 16'sd0 && ay == 16'sd0 && az == 16'sd0) begin
      c.stat = ST_ZERO_ACC;
    end else if ($signed(cfg[REG_X_HIGH]) <= $signed(cfg[REG_X_LOW]) ||
                 $signed(cfg[REG_Y_HIGH]) <= $signed(cfg[REG_Y_LOW]) ||
                 $signed(cfg[REG_Z_HIGH]) <= $signed(cfg[REG_Z_LOW])) begin
      c.stat = ST_BAD_CAL;
    end else begin
      c.stat = ST_OK;
    end
    for (int a = 0; a < 3; a++) begin
      lo  = 17'($signed(cfg[int'(REG_X_LOW) + a]));
      hi  = 17'($signed(cfg[int'(REG_X_HIGH) + a]));
      raw = 17'($signed(m[a]));
      dd  = hi - lo;
      rl  = raw - lo;
      num = {rl[16], rl, 1'b0} - 19'(dd);
      nm  = num[18] ? 19'(-num) : 19'(num);
      c.nneg[a] = num[18];
      c.nd[a]   = dd;
      c.nrem[a] = 35'({nm, 16'h0000}) + 35'(dd[16:1]);
    end
    return c;
  endfunction

  function automatic ctx_t st_sq(ctx_t c);
    c.sqx = 32'(c.ax * c.ax);
    c.sqy = 32'(c.ay * c.ay);
    c.sqz = 32'(c.az * c.az);
    for (int a = 0; a < 3; a++) begin
      c.novf[a] = 36'(c.nrem[a]) >= (36'(c.nd[a]) << N_NQ);
    end
    return c;
  endfunction

  function automatic ctx_t st_sum(ctx_t c);
    c.sv = {c.sqx + c.sqy + c.sqz, 32'h0};
    c.sr = '0;
    return c;
  endfunction

  // one bit of the magnitude root, plus one bit of each axis normalisation divide while j < N_NQ
  function automatic ctx_t st_sqs(ctx_t c, int j);
    logic [35:0] dsh;
    c = sqrt_bit(c, N_SQS - 1 - j);
    if (j < N_NQ) begin
      for (int a = 0; a < 3; a++) begin
        dsh = 36'(c.nd[a]) << (N_NQ - 1 - j);
        if (36'(c.nrem[a]) >= dsh) begin
          c.nrem[a] = c.nrem[a] - 35'(dsh);
          c.nq[a][N_NQ-1-j] = 1'b1;
        end
      end
    end
    return c;
  endfunction

  function automatic ctx_t st_prep(ctx_t c);
    logic [16:0] am, bm;
    c.dsor = c.sr[32:0];
    am = c.ax[15] ? 17'(-17'(c.ax)) : 17'(c.ax);
    bm = c.ay[15] ? 17'(-17'(c.ay)) : 17'(c.ay);
    c.drem0 = 49'({am, 32'h0}) + 49'(c.dsor[32:1]);
    c.drem1 = 49'({bm, 32'h0}) + 49'(c.dsor[32:1]);
    c.dq0 = '0;
    c.dq1 = '0;
    // saturate normalised axes to [-2, 2)
    for (int a = 0; a < 3; a++) begin
      if (c.nneg[a]) begin
        c.nv[a] = (c.novf[a] || c.nq[a] > 19'd131072) ? 18'h20000 : 18'(-c.nq[a]);
      end else begin
        c.nv[a] = (c.novf[a] || c.nq[a] > 19'd131071) ? 18'h1ffff : 18'(c.nq[a]);
      end
    end
    return c;
  endfunction

  function automatic ctx_t st_dvp(ctx_t c, int j);
    logic [48:0] dsh;
    dsh = 49'(c.dsor) << (N_DIV - 1 - j);
    if (c.drem0 >= dsh) begin
      c.drem0 = c.drem0 - dsh;
      c.dq0[N_DIV-1-j] = 1'b1;
    end
    if (c.drem1 >= dsh) begin
      c.drem1 = c.drem1 - dsh;
      c.dq1[N_DIV-1-j] = 1'b1;
    end
    return c;
  endfunction

  function automatic ctx_t st_cpin(ctx_t c);
    c.sin_p = (c.ax > 16'sd0) ? -$signed({1'b0, c.dq0}) : $signed({1'b0, c.dq0});
    c.ayn   = (c.ay < 16'sd0) ? -$signed({1'b0, c.dq1}) : $signed({1'b0, c.dq1});
    c.sv = (64'(1) << 32) - 64'(c.dq0 * c.dq0);
    c.sr = '0;
    return c;
  endfunction

  function automatic ctx_t st_sqc(ctx_t c, int j);
    return sqrt_bit(c, N_SQC - 1 - j);
  endfunction

  function automatic ctx_t st_rin(ctx_t c);
    logic [16:0] m;
    c.cos_p = c.sr[16:0];
    if (c.stat == ST_OK && c.cos_p == 17'd0) begin
      c.stat = ST_PITCH;
    end
    m = c.ayn[17] ? 17'(-c.ayn) : 17'(c.ayn);
    c.rrem = 34'({m, 16'h0000}) + 34'(c.cos_p[16:1]);
    c.rovf = {1'b0, c.rrem} >= (35'(c.cos_p) << N_DIV);
    c.rq = '0;
    return c;
  endfunction

  function automatic ctx_t st_rdv(ctx_t c, int j);
    logic [33:0] dsh;
    dsh = 34'(c.cos_p) << (N_DIV - 1 - j);
    if (c.rrem >= dsh) begin
      c.rrem = c.rrem - dsh;
      c.rq[N_DIV-1-j] = 1'b1;
    end
    return c;
  endfunction

  function automatic ctx_t st_crin(ctx_t c);
    logic [16:0] m;
    m = (c.rovf || c.rq > 17'd65536) ? 17'd65536 : c.rq;
    c.sin_r = c.ayn[17] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    c.sv = (64'(1) << 32) - 64'(m * m);
    c.sr = '0;
    return c;
  endfunction

  function automatic ctx_t st_mul(ctx_t c);
    c.p1 = $signed(c.nv[0]) * $signed({1'b0, c.cos_p});
    c.p2 = $signed(c.nv[2]) * c.sin_p;
    c.p3 = $signed(c.nv[0]) * c.sin_r;
    c.p4 = $signed(c.nv[1]) * $signed({1'b0, c.sr[16:0]});
    c.p5 = $signed(c.nv[2]) * c.sin_r;
    return c;
  endfunction

  function automatic ctx_t st_acc(ctx_t c);
    c.cx = (56'(c.p1) + 56'(c.p2)) <<< 16;
    c.t1 = c.p3 * c.sin_p;
    c.t2 = c.p5 * $signed({1'b0, c.cos_p});
    return c;
  endfunction

  function automatic ctx_t st_ysum(ctx_t c);
    c.cy = 56'(c.t1) + (56'(c.p4) <<< 16) - 56'(c.t2);
    return c;
  endfunction

  function automatic ctx_t st_cpre(ctx_t c);
    c.nullv = (c.cx == 56'sd0) && (c.cy == 56'sd0);
    if (c.cx < 56'sd0) begin
      c.cx  = -c.cx;
      c.cy  = -c.cy;
      c.ang = 24'(HALF_TURN);
    end else begin
      c.ang = '0;
    end
    return c;
  endfunction

  function automatic ctx_t st_cord(ctx_t c, int i);
    logic signed [55:0] dx, dy;
    dx = c.cy >>> i;
    dy = c.cx >>> i;
    if (c.cy > 56'sd0) begin
      c.cx  = c.cx + dx;
      c.cy  = c.cy - dy;
      c.ang = c.ang + 24'(ATAN_T[i]);
    end else begin
      c.cx  = c.cx - dx;
      c.cy  = c.cy + dy;
      c.ang = c.ang - 24'(ATAN_T[i]);
    end
    return c;
  endfunction

  function automatic ctx_t st_fin(ctx_t c);
    logic signed [24:0] t, v;
    t = 25'sd128 - 25'(c.ang);
    v = t >>> 8;
    if (v < 25'sd0) begin
      v = v + 25'(CIRCLE_CODES);
    end
    c.hdg = (c.stat != ST_OK || c.nullv) ? 15'd0 : 15'(v);
    return c;
  endfunction

endpackage

/* design/tilt_compensated_compass_heading.sv */
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tcch_pkg and tilt_compensated_compass_heading_macros.svh.
//
// channel   | ports                                    | handshake
// ----------+------------------------------------------+-------------------------
// samples   | mag_x/y/z, acc_x/y/z                      | start & !busy
// result    | heading, status                           | done, one cycle, no stall
// config    | cfg_index, cfg_data                       | cfg_write
//
// One transaction per clock; busy stays low. The result strobe comes out of the
// last stage, after the chain of one-bit-per-stage square roots, dividers and
// the 17-step CORDIC. rst clears the stage valid bits and loads the calibration
// registers with their defaults. Nothing in the pipeline ever stalls.
`include "tilt_compensated_compass_heading_macros.svh"
module tilt_compensated_compass_heading
  import tcch_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  output logic               done,
  output logic [14:0]        heading,
  output logic [1:0]         status,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [REG_COUNT-1:0][15:0] cfg_reg;
  ctx_t pipe [N_ST];
  ctx_t pipe_next [N_ST];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= CFG_RESET;
    end else if (cfg_write && cfg_index < 3'(REG_COUNT)) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  assign pipe_next[0] = st_entry(start && !busy, {mag_z, mag_y, mag_x},
                                 acc_x, acc_y, acc_z, cfg_reg);

  for (genvar i = 1; i < N_ST; i++) begin : g_st
    if (i == ST_SQ) begin : g_sq
      assign pipe_next[i] = st_sq(pipe[i-1]);
    end else if (i == ST_SUM) begin : g_sum
      assign pipe_next[i] = st_sum(pipe[i-1]);
    end else if (i < ST_PREP) begin : g_sqs
      assign pipe_next[i] = st_sqs(pipe[i-1], i - ST_SQS);
    end else if (i == ST_PREP) begin : g_prep
      assign pipe_next[i] = st_prep(pipe[i-1]);
    end else if (i < ST_CPIN) begin : g_dvp
      assign pipe_next[i] = st_dvp(pipe[i-1], i - ST_DVP);
    end else if (i == ST_CPIN) begin : g_cpin
      assign pipe_next[i] = st_cpin(pipe[i-1]);
    end else if (i < ST_RIN) begin : g_cps
      assign pipe_next[i] = st_sqc(pipe[i-1], i - ST_CPS);
    end else if (i == ST_RIN) begin : g_rin
      assign pipe_next[i] = st_rin(pipe[i-1]);
    end else if (i < ST_CRIN) begin : g_rdv
      assign pipe_next[i] = st_rdv(pipe[i-1], i - ST_RDV);
    end else if (i == ST_CRIN) begin : g_crin
      assign pipe_next[i] = st_crin(pipe[i-1]);
    end else if (i < ST_MUL) begin : g_crs
      assign pipe_next[i] = st_sqc(pipe[i-1], i - ST_CRS);
    end else if (i == ST_MUL) begin : g_mul
      assign pipe_next[i] = st_mul(pipe[i-1]);
    end else if (i == ST_ACC) begin : g_acc
      assign pipe_next[i] = st_acc(pipe[i-1]);
    end else if (i == ST_YSUM) begin : g_ysum
      assign pipe_next[i] = st_ysum(pipe[i-1]);
    end else if (i == ST_CPRE) begin : g_cpre
      assign pipe_next[i] = st_cpre(pipe[i-1]);
    end else if (i < ST_FIN) begin : g_cord
      assign pipe_next[i] = st_cord(pipe[i-1], i - ST_CORD);
    end else begin : g_fin
      assign pipe_next[i] = st_fin(pipe[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ST; i++) begin
      pipe[i] <= rst ? ctx_t'('0) : pipe_next[i];
    end
  end

  assign done    = pipe[ST_FIN].vld;
  assign heading = pipe[ST_FIN].hdg;
  assign status  = pipe[ST_FIN].stat;

  `TCCH_ASSERT_NOW(a_flag_clears_heading, done && (status != ST_OK), heading == 15'd0)
  `TCCH_ASSERT_NOW(a_heading_range, done, heading < 15'(CIRCLE_CODES))
  `TCCH_ASSERT_NEXT(a_cfg_x_low, cfg_write && (cfg_index == REG_X_LOW), cfg_reg[REG_X_LOW] == $past(cfg_data))

endmodule
